### rtl/tlnt_pkg.sv
// ----------------------------------------------------------------------------
// tlnt_pkg
// Shared types, sizes and codes for the two-level name table.
// ----------------------------------------------------------------------------
package tlnt_pkg;

  localparam int MAX_DIRS      = 128;
  localparam int FILES_PER_DIR = 64;
  localparam int KEY_BITS      = 64;

  localparam int DIR_W      = (MAX_DIRS > 1) ? $clog2(MAX_DIRS) : 1;
  localparam int SLOT_W     = (FILES_PER_DIR > 1) ? $clog2(FILES_PER_DIR) : 1;
  localparam int CNT_W      = $clog2(MAX_DIRS + 1);
  localparam int FILE_DEPTH = MAX_DIRS << SLOT_W;
  localparam int FILE_W     = KEY_BITS + 1;

  localparam int IN_KEY_W   = 64;
  localparam int DIR_IDX_W  = 7;
  localparam int SLOT_IDX_W = 6;

  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_NO_DIR  = 2'd1,
    STS_NO_FILE = 2'd2,
    STS_FULL    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CLEAR,
    S_DIR_SCAN,
    S_FILE_SCAN
  } state_t;

endpackage

### rtl/two_level_name_table_unit.sv
// ----------------------------------------------------------------------------
// two_level_name_table_unit
// Two-level name table: directory keys in one RAM, file keys with valid
// marks in a second RAM, searched one entry per cycle.
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+------------------------
//   request  | in_cmd, in_dir_key, in_file_key         | start high, busy low
//   result   | out_status, out_dir_index, out_file_slot| out_valid, one cycle
//
// create clears the new directory's valid marks one slot a cycle through the
// file RAM write port. insert, delete and search read the directory RAM one
// entry a cycle, then the file RAM one entry a cycle.
// reset clears the directory count but not the RAMs; a directory's slots are
// cleared when it is created, so no pass over the RAMs follows reset.
// the result receiver cannot stall; busy stays high until the result strobe.
// ----------------------------------------------------------------------------
module two_level_name_table_unit
  import tlnt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_cmd,
  input  logic [IN_KEY_W-1:0]   in_dir_key,
  input  logic [IN_KEY_W-1:0]   in_file_key,
  output logic                  out_valid,
  output logic [1:0]            out_status,
  output logic [DIR_IDX_W-1:0]  out_dir_index,
  output logic [SLOT_IDX_W-1:0] out_file_slot
);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(FILES_PER_DIR - 1);

  state_t                  state_r, state_nxt;
  cmd_t                    cmd_r, cmd_nxt;
  logic [KEY_BITS-1:0]     dkey_r, dkey_nxt;
  logic [KEY_BITS-1:0]     fkey_r, fkey_nxt;
  logic [CNT_W-1:0]        dir_used_r, dir_used_nxt;
  logic [DIR_W-1:0]        dir_sel_r, dir_sel_nxt;
  logic [DIR_W-1:0]        idx_r, idx_nxt;
  logic [DIR_W-1:0]        cmp_dir_r, cmp_dir_nxt;
  logic [SLOT_W-1:0]       slot_r, slot_nxt;
  logic [SLOT_W-1:0]       cmp_slot_r, cmp_slot_nxt;
  logic                    pend_r, pend_nxt;
  logic                    out_valid_r, out_valid_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic [DIR_IDX_W-1:0]    out_dir_r, out_dir_nxt;
  logic [SLOT_IDX_W-1:0]   out_slot_r, out_slot_nxt;

  logic                    accept;
  logic                    table_full;
  logic                    dir_hit;
  logic                    dir_last;
  logic                    file_valid;
  logic [KEY_BITS-1:0]     file_name;
  logic                    file_hit;
  logic                    file_last;

  logic                    dir_we;
  logic [DIR_W-1:0]        dir_waddr;
  logic [DIR_W-1:0]        dir_raddr;
  logic [KEY_BITS-1:0]     dir_rdata;
  logic                    file_we;
  logic [DIR_W+SLOT_W-1:0] file_waddr;
  logic [FILE_W-1:0]       file_wdata;
  logic [DIR_W+SLOT_W-1:0] file_raddr;
  logic [FILE_W-1:0]       file_rdata;

  assign accept     = start && (state_r == S_IDLE);
  assign table_full = (dir_used_r == CNT_W'(MAX_DIRS));
  assign dir_hit    = pend_r && (dir_rdata == dkey_r);
  assign dir_last   = (CNT_W'(cmp_dir_r) + CNT_W'(1)) == dir_used_r;
  assign file_valid = file_rdata[KEY_BITS];
  assign file_name  = file_rdata[KEY_BITS-1:0];
  assign file_hit   = pend_r && ((cmd_r == CMD_INSERT) ? !file_valid
                                 : (file_valid && (file_name == fkey_r)));
  assign file_last  = (cmp_slot_r == LAST_SLOT);

  tlnt_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (MAX_DIRS)
  ) u_dir_ram (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_waddr),
    .wdata (in_dir_key[KEY_BITS-1:0]),
    .raddr (dir_raddr),
    .rdata (dir_rdata)
  );

  tlnt_ram #(
    .WIDTH (FILE_W),
    .DEPTH (FILE_DEPTH)
  ) u_file_ram (
    .clk   (clk),
    .we    (file_we),
    .waddr (file_waddr),
    .wdata (file_wdata),
    .raddr (file_raddr),
    .rdata (file_rdata)
  );

  // next state and datapath
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    dkey_nxt       = dkey_r;
    fkey_nxt       = fkey_r;
    dir_used_nxt   = dir_used_r;
    dir_sel_nxt    = dir_sel_r;
    idx_nxt        = idx_r;
    cmp_dir_nxt    = cmp_dir_r;
    slot_nxt       = slot_r;
    cmp_slot_nxt   = cmp_slot_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_dir_nxt    = out_dir_r;
    out_slot_nxt   = out_slot_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt  = cmd_t'(in_cmd);
          dkey_nxt = in_dir_key[KEY_BITS-1:0];
          fkey_nxt = in_file_key[KEY_BITS-1:0];
          if (cmd_t'(in_cmd) == CMD_CREATE) begin
            if (table_full) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STS_FULL;
              out_dir_nxt    = '0;
              out_slot_nxt   = '0;
            end else begin
              dir_sel_nxt  = DIR_W'(dir_used_r);
              dir_used_nxt = dir_used_r + CNT_W'(1);
              slot_nxt     = '0;
              state_nxt    = S_CLEAR;
            end
          end else if (dir_used_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STS_NO_DIR;
            out_dir_nxt    = '0;
            out_slot_nxt   = '0;
          end else begin
            idx_nxt   = '0;
            pend_nxt  = 1'b0;
            state_nxt = S_DIR_SCAN;
          end
        end
      end
      S_CLEAR: begin
        slot_nxt = slot_r + SLOT_W'(1);
        if (slot_r == LAST_SLOT) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STS_OK;
          out_dir_nxt    = DIR_IDX_W'(dir_sel_r);
          out_slot_nxt   = '0;
          state_nxt      = S_IDLE;
        end
      end
      S_DIR_SCAN: begin
        idx_nxt     = idx_r + DIR_W'(1);
        cmp_dir_nxt = idx_r;
        pend_nxt    = 1'b1;
        priority if (dir_hit) begin
          dir_sel_nxt = cmp_dir_r;
          slot_nxt    = '0;
          pend_nxt    = 1'b0;
          state_nxt   = S_FILE_SCAN;
        end else if (pend_r && dir_last) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STS_NO_DIR;
          out_dir_nxt    = '0;
          out_slot_nxt   = '0;
          state_nxt      = S_IDLE;
        end
      end
      S_FILE_SCAN: begin
        slot_nxt     = slot_r + SLOT_W'(1);
        cmp_slot_nxt = slot_r;
        pend_nxt     = 1'b1;
        priority if (file_hit) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STS_OK;
          out_dir_nxt    = DIR_IDX_W'(dir_sel_r);
          out_slot_nxt   = SLOT_IDX_W'(cmp_slot_r);
          state_nxt      = S_IDLE;
        end else if (pend_r && file_last) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = (cmd_r == CMD_INSERT) ? STS_FULL : STS_NO_FILE;
          out_dir_nxt    = DIR_IDX_W'(dir_sel_r);
          out_slot_nxt   = '0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // ram controls and handshake
  always_comb begin
    busy       = 1'b1;
    dir_we     = 1'b0;
    dir_waddr  = DIR_W'(dir_used_r);
    dir_raddr  = idx_r;
    file_we    = 1'b0;
    file_waddr = {dir_sel_r, cmp_slot_r};
    file_wdata = {1'b0, file_name};
    file_raddr = {dir_sel_r, slot_r};
    unique case (state_r)
      S_IDLE: begin
        busy   = 1'b0;
        dir_we = accept && (cmd_t'(in_cmd) == CMD_CREATE) && !table_full;
      end
      S_CLEAR: begin
        file_we    = 1'b1;
        file_waddr = {dir_sel_r, slot_r};
        file_wdata = '0;
      end
      S_DIR_SCAN: begin
      end
      S_FILE_SCAN: begin
        file_we = file_hit && (cmd_r != CMD_SEARCH);
        if (cmd_r == CMD_INSERT) begin
          file_wdata = {1'b1, fkey_r};
        end
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dir_used_r  <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dir_used_r  <= dir_used_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    dkey_r       <= dkey_nxt;
    fkey_r       <= fkey_nxt;
    dir_sel_r    <= dir_sel_nxt;
    idx_r        <= idx_nxt;
    cmp_dir_r    <= cmp_dir_nxt;
    slot_r       <= slot_nxt;
    cmp_slot_r   <= cmp_slot_nxt;
    out_status_r <= out_status_nxt;
    out_dir_r    <= out_dir_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_dir_index = out_dir_r;
  assign out_file_slot = out_slot_r;

endmodule

### rtl/tlnt_ram.sv
// ----------------------------------------------------------------------------
// tlnt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tlnt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/tlnt_checker.sv
// ----------------------------------------------------------------------------
// tlnt_checker
// Port-level checks on the two-level name table, bound to the top level.
// ----------------------------------------------------------------------------
module tlnt_checker
  import tlnt_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  out_valid,
  input logic [1:0]            out_status,
  input logic [DIR_IDX_W-1:0]  out_dir_index,
  input logic [SLOT_IDX_W-1:0] out_file_slot
);

  // a result closes its request
  a_result_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  // every accepted request either works on or answers at once
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted request dropped");

  a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy raised without a request");

  a_no_dir_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STS_NO_DIR)) |->
      ((out_dir_index == '0) && (out_file_slot == '0)))
    else $error("directory miss with nonzero indices");

  a_fail_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((out_status == STS_FULL) || (out_status == STS_NO_FILE))) |->
      (out_file_slot == '0))
    else $error("failed request with nonzero slot");

endmodule

bind two_level_name_table_unit tlnt_checker u_tlnt_checker (.*);
